// ===== hw/rtl/a85_pkg.sv =====
// Shared types, character codes and base-85 power table for the Ascii85 decoder.
package a85_pkg;

  localparam logic [7:0] CHAR_FIRST = 8'h21;  // '!'
  localparam logic [7:0] CHAR_LAST  = 8'h75;  // 'u'
  localparam logic [7:0] CHAR_END   = 8'h7E;  // '~'

  localparam logic [2:0] GROUP_DIGITS = 3'd5;

  localparam int BURST_DEPTH_DEF = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;
  } out_item_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [2:0]  count;
    logic        terminated;
  } dec_state_t;

  // Bytes produced by one character: top nbytes of word, or a lone end marker.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        marker;
    logic        stream_end;
  } burst_t;

  // 85^idx modulo 2^32 for idx 0 to 5; other indices give 1
  function automatic logic [31:0] pow85(input logic [2:0] idx);
    logic [31:0] p;
    case (idx)
      3'd1:    p = 32'd85;
      3'd2:    p = 32'd7225;
      3'd3:    p = 32'd614125;
      3'd4:    p = 32'd52200625;
      3'd5:    p = 32'd142085829;  // 85^5 - 2^32
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/ascii85_stream_decoder_top.sv =====
// Top level of the Ascii85 stream decoder: input register, decode step, byte queue.
//
// Takes one character per cycle on the char channel while char_ready is high
// and gives decoded bytes, big-endian, one per transfer on the res channel.
// A character is held in the input register and decoded combinationally;
// its bytes leave at one per cycle, while res_ready is high, from a burst
// queue, so a completed group of five digits gives four results; a character
// with no result does not wait for queue room. Input keeps one character
// per cycle while the queue (DEPTH bursts) has room; it drains one byte per
// cycle while res_ready is high, matching the four bytes that five characters
// make. The decode path is one 32x32 multiply by a power of 85 plus one add.
module ascii85_stream_decoder_top #(
  parameter int DEPTH = a85_pkg::BURST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_ready,
  input  a85_pkg::in_item_t  char_data,
  output logic               res_valid,
  input  logic               res_ready,
  output a85_pkg::out_item_t res_data
);
  import a85_pkg::*;

  in_item_t   in_q;
  logic       in_q_valid;
  dec_state_t state;
  dec_state_t state_next;
  burst_t     burst;
  logic       has_result;
  logic       push_ready;
  logic       advance;
  logic       push;

  a85_step u_step (
    .state      (state),
    .item       (in_q),
    .state_next (state_next),
    .burst      (burst)
  );

  assign has_result = burst.marker || (burst.nbytes != 3'd0);
  assign advance    = in_q_valid && (!has_result || push_ready);
  assign push       = advance && has_result;
  assign char_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      in_q <= char_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      state      <= '0;
    end else begin
      if (char_ready) begin
        in_q_valid <= char_valid;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  a85_serialiser #(
    .DEPTH (DEPTH)
  ) u_serialiser (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (burst),
    .push_ready (push_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

`ifndef NO_ASSERTIONS
  // an end marker closes its character's results
  a_marker_closes : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.byte_valid) |-> (res_data.run_last && res_data.stream_end))
    else $error("end marker transfer without run_last and stream_end");

  // after the end mark, non-final characters give nothing
  a_terminated_quiet : assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && state.terminated && !in_q.stream_last) |-> !has_result)
    else $error("result produced after end mark");

  // the final character returns the group state to reset
  a_stream_reset : assert property (@(posedge clk) disable iff (rst)
    (advance && in_q.stream_last) |=> (state == '0))
    else $error("state not cleared after final character");

  // a partial group never holds five digits
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    state.count <= 3'd4)
    else $error("digit count out of range");
`endif

endmodule

// ===== hw/rtl/a85_step.sv =====
// Combinational decode of one character against the current group state.
module a85_step (
  input  a85_pkg::dec_state_t state,
  input  a85_pkg::in_item_t   item,
  output a85_pkg::dec_state_t state_next,
  output a85_pkg::burst_t     burst
);
  import a85_pkg::*;

  logic        is_digit;
  logic        is_end;
  logic [6:0]  digit;
  logic [7:0]  digit_inc;
  logic [2:0]  count_inc;
  logic [2:0]  sel_flush;
  logic [2:0]  sel_pad;
  logic [31:0] mult_k;
  logic [31:0] add_b;
  logic [31:0] pad_term;
  logic [31:0] prod;
  logic [31:0] word;
  logic [2:0]  flush_bytes;
  logic [2:0]  nbytes;
  logic [7:0]  code_off;

  assign code_off  = item.char_code - CHAR_FIRST;
  assign digit     = code_off[6:0];
  assign digit_inc = {1'b0, digit} + 8'd1;
  assign is_digit  = (item.char_code >= CHAR_FIRST) && (item.char_code <= CHAR_LAST);
  assign is_end    = (item.char_code == CHAR_END);
  assign count_inc = state.count + 3'd1;
  assign sel_flush = GROUP_DIGITS - state.count;
  assign sel_pad   = GROUP_DIGITS - count_inc;

  // padding a partial group with 84s folds to (x+1)*85^m - 1
  assign pad_term    = {24'd0, digit_inc} * pow85(sel_pad);
  assign prod        = state.acc * mult_k;
  assign word        = prod + add_b;
  assign flush_bytes = (state.count == 3'd0) ? 3'd0 : state.count - 3'd1;

  always_comb begin
    state_next = state;
    nbytes     = 3'd0;
    mult_k     = pow85(3'd1);
    add_b      = 32'd0;
    if (!state.terminated) begin
      priority if (is_end) begin
        mult_k     = pow85(sel_flush);
        add_b      = pow85(sel_flush) - 32'd1;
        nbytes     = flush_bytes;
        state_next = '{acc: 32'd0, count: 3'd0, terminated: 1'b1};
      end else if (is_digit) begin
        if (count_inc == GROUP_DIGITS) begin
          add_b      = {25'd0, digit};
          nbytes     = 3'd4;
          state_next = '{acc: 32'd0, count: 3'd0, terminated: 1'b0};
        end else if (item.stream_last) begin
          mult_k = pow85(sel_flush);
          add_b  = pad_term - 32'd1;
          nbytes = state.count;
        end else begin
          add_b      = {25'd0, digit};
          state_next = '{acc: word, count: count_inc, terminated: 1'b0};
        end
      end else if (item.stream_last) begin
        mult_k = pow85(sel_flush);
        add_b  = pow85(sel_flush) - 32'd1;
        nbytes = flush_bytes;
      end
    end
    if (item.stream_last) begin
      state_next = '0;
    end
  end

  assign burst.word       = word;
  assign burst.nbytes     = nbytes;
  assign burst.marker     = item.stream_last && (nbytes == 3'd0);
  assign burst.stream_end = item.stream_last;

endmodule

// ===== hw/rtl/a85_serialiser.sv =====
// Burst queue that hands out decoded bytes one transfer at a time.
module a85_serialiser #(
  parameter int DEPTH = a85_pkg::BURST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  a85_pkg::burst_t    push_data,
  output logic               push_ready,
  output logic               res_valid,
  input  logic               res_ready,
  output a85_pkg::out_item_t res_data
);
  import a85_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  burst_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic [1:0]       idx;
  burst_t           head;
  logic             burst_done;
  logic             pop;
  logic [7:0]       sel_byte;

  assign head       = mem[rd_ptr];
  assign res_valid  = (fill != '0);
  assign push_ready = (fill != CNT_FULL);
  assign burst_done = head.marker || ({1'b0, idx} == head.nbytes - 3'd1);
  assign pop        = res_valid && res_ready && burst_done;

  always_comb begin
    unique case (idx)
      2'd0: sel_byte = head.word[31:24];
      2'd1: sel_byte = head.word[23:16];
      2'd2: sel_byte = head.word[15:8];
      2'd3: sel_byte = head.word[7:0];
    endcase
  end

  assign res_data.data_byte  = head.marker ? 8'd0 : sel_byte;
  assign res_data.byte_valid = !head.marker;
  assign res_data.run_last   = burst_done;
  assign res_data.stream_end = head.stream_end;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      idx    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
      if (res_valid && res_ready) begin
        idx <= burst_done ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule
